[sv/pbss_pkg.sv]
// Package for the priority bucket sprite sorter.
// Holds default sizes, field widths, result codes and controller/datapath interface structs.
// No dependencies.
package pbss_pkg;

  localparam int NUM_BUCKETS_DEF  = 512;
  localparam int BUCKET_DEPTH_DEF = 14;
  localparam int TOTAL_LIMIT_DEF  = 128;

  localparam int PRIO_W  = 9;
  localparam int IDX_W   = 8;
  localparam int SLOT_W  = 7;
  localparam int CNT_W   = 8;
  localparam int POS_W   = 4;
  localparam int QUO_W   = 6;
  localparam int RECIP_SH = 18;

  localparam logic [CNT_W:0] SLOT_LIMIT = 9'h07F;

  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_TABLE_FULL  = 3'd1,
    ST_BUCKET_FULL = 3'd2,
    ST_SORTED      = 3'd3,
    ST_EMPTY       = 3'd4,
    ST_OVERFLOW    = 3'd5
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic refuse;
    logic ins_commit;
    logic empty_end;
    logic over_end;
    logic drain_start;
    logic drain_lost;
    logic drain_skip;
    logic drain_fix;
    logic drain_commit;
    logic clr_step;
    logic fin_move;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic kind;
    logic draining;
    logic refuse;
    logic main_zero;
    logic over;
    logic bkt_end;
    logic cnt_zero;
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage

[sv/pbss_ctrl.sv]
// Controller state machine for the priority bucket sprite sorter.
// Sequences insert, drain and clearing-pass steps. Depends on pbss_pkg.
module pbss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pbss_pkg::dp_sts_t sts_i,
  output pbss_pkg::dp_cmd_t cmd_o
);
  import pbss_pkg::*;

  typedef enum logic [10:0] {
    S_CLR    = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_DEC    = 11'b00000000100,
    S_INS_A  = 11'b00000001000,
    S_INS_RD = 11'b00000010000,
    S_INS_WR = 11'b00000100000,
    S_DR_RD  = 11'b00001000000,
    S_DR_CHK = 11'b00010000000,
    S_DR_ADR = 11'b00100000000,
    S_DR_ENT = 11'b01000000000,
    S_FIN    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   clr_after_q, clr_after_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_d     = state_q;
    clr_after_d = clr_after_q;
    cmd_o       = '0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          clr_after_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts_i.kind) begin
          if (sts_i.refuse) begin
            cmd_o.refuse = 1'b1;
            state_d      = S_FIN;
          end else begin
            state_d = S_INS_A;
          end
        end else if (sts_i.draining) begin
          state_d = S_DR_RD;
        end else if (sts_i.main_zero) begin
          cmd_o.empty_end = 1'b1;
          state_d         = S_FIN;
        end else if (sts_i.over) begin
          cmd_o.over_end = 1'b1;
          clr_after_d    = 1'b1;
          state_d        = S_FIN;
        end else begin
          cmd_o.drain_start = 1'b1;
          state_d           = S_DR_RD;
        end
      end
      S_INS_A:  state_d = S_INS_RD;
      S_INS_RD: state_d = S_INS_WR;
      S_INS_WR: begin
        cmd_o.ins_commit = 1'b1;
        state_d          = S_FIN;
      end
      S_DR_RD: begin
        if (sts_i.bkt_end) begin
          cmd_o.drain_lost = 1'b1;
          clr_after_d      = 1'b1;
          state_d          = S_FIN;
        end else begin
          state_d = S_DR_CHK;
        end
      end
      S_DR_CHK: begin
        if (sts_i.cnt_zero) begin
          cmd_o.drain_skip = 1'b1;
          state_d          = S_DR_RD;
        end else begin
          cmd_o.drain_fix = 1'b1;
          state_d         = S_DR_ADR;
        end
      end
      S_DR_ADR: state_d = S_DR_ENT;
      S_DR_ENT: begin
        cmd_o.drain_commit = 1'b1;
        state_d            = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin_move = 1'b1;
          state_d        = clr_after_q ? S_CLR : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State registers; reset starts with the count clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_after_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_after_q <= clr_after_d;
    end
  end

endmodule

[sv/pbss_datapath.sv]
// Datapath for the priority bucket sprite sorter: count and entry memories,
// frame counters, drain pointers and result registers. Depends on pbss_pkg.
module pbss_datapath #(
  parameter int NUM_BUCKETS  = pbss_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = pbss_pkg::BUCKET_DEPTH_DEF,
  parameter int TOTAL_LIMIT  = pbss_pkg::TOTAL_LIMIT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        kind_i,
  input  logic [pbss_pkg::PRIO_W-1:0] priority_req_i,
  input  logic [pbss_pkg::IDX_W-1:0]  entry_index_i,
  input  logic                        want_shadow_i,
  input  pbss_pkg::dp_cmd_t           cmd_i,
  output pbss_pkg::dp_sts_t           sts_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [2:0]                  status_o,
  output logic [pbss_pkg::IDX_W-1:0]  sorted_index_o,
  output logic [pbss_pkg::SLOT_W-1:0] hw_slot_o,
  output logic                        shadow_granted_o,
  output logic [pbss_pkg::SLOT_W-1:0] shadow_slot_o,
  output logic                        last_o
);
  import pbss_pkg::*;

  localparam int BW     = $clog2(NUM_BUCKETS);
  localparam int NENT   = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int EW     = $clog2(NENT);
  localparam int MW     = BW + 10;
  localparam int RECIP  = (1 << RECIP_SH) / NUM_BUCKETS;

  // Captured transaction
  logic              kind_q;
  logic [PRIO_W-1:0] prio_q;
  logic [IDX_W-1:0]  idx_q;
  logic              ws_q;

  // Bucket number pipeline (priority modulo bucket count)
  logic [31:0]       prod;
  logic [QUO_W-1:0]  quo_q;
  logic [MW-1:0]     qn, rem0, rem;
  logic [BW-1:0]     ins_bkt_q;

  // Memories
  logic [POS_W-1:0]  cnt_mem [NUM_BUCKETS];
  logic [POS_W-1:0]  cnt_rd_q;
  logic [BW-1:0]     cnt_raddr, cnt_waddr;
  logic [POS_W-1:0]  cnt_wdata;
  logic              cnt_we;
  logic [IDX_W-1:0]  ent_mem [NENT];
  logic [IDX_W-1:0]  ent_rd_q;
  logic [EW-1:0]     ent_addr;
  logic [BW-1:0]     e_bkt;
  logic [POS_W-1:0]  e_pos;
  logic              ent_we;

  // Frame state
  logic [CNT_W-1:0]  main_q, shadow_q, drained_q;
  logic [BW:0]       bkt_q;
  logic [POS_W-1:0]  pos_q;
  logic              draining_q;
  logic [BW-1:0]     clr_q;

  // Staged and output result
  logic [2:0]        res_status_q, out_status_q;
  logic [IDX_W-1:0]  res_sorted_q, out_sorted_q;
  logic [SLOT_W-1:0] res_slot_q, out_slot_q;
  logic              res_grant_q, out_grant_q;
  logic [SLOT_W-1:0] res_sslot_q, out_sslot_q;
  logic              res_last_q, out_last_q;
  logic              out_valid_q;

  // Insert and drain arithmetic
  logic [CNT_W:0]    sum;
  logic              room;
  logic [CNT_W-1:0]  main_new;
  logic              grant;
  logic [CNT_W:0]    drained_n;
  logic [POS_W:0]    pos_n;
  logic              frame_done, bkt_done;

  assign sum = {1'b0, main_q} + {1'b0, shadow_q};

  // Status toward the controller
  always_comb begin
    sts_o.kind      = kind_q;
    sts_o.draining  = draining_q;
    sts_o.refuse    = draining_q || (sum >= (CNT_W+1)'(TOTAL_LIMIT));
    sts_o.main_zero = (main_q == '0);
    sts_o.over      = (sum > SLOT_LIMIT);
    sts_o.bkt_end   = (bkt_q >= (BW+1)'(NUM_BUCKETS));
    sts_o.cnt_zero  = (cnt_rd_q == '0);
    sts_o.clr_last  = (clr_q == BW'(NUM_BUCKETS - 1));
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // Modulo by reciprocal: quotient register, then one correction step
  assign prod = 32'(prio_q) * 32'(RECIP);
  assign qn   = MW'(quo_q) * MW'(NUM_BUCKETS);
  assign rem0 = MW'(prio_q) - qn;
  assign rem  = (rem0 >= MW'(NUM_BUCKETS)) ? (rem0 - MW'(NUM_BUCKETS)) : rem0;

  always_ff @(posedge clk_i) begin
    quo_q     <= QUO_W'(prod >> RECIP_SH);
    ins_bkt_q <= BW'(rem);
  end

  // Insert decision
  assign room     = (cnt_rd_q < POS_W'(BUCKET_DEPTH));
  assign main_new = main_q + CNT_W'(room);
  assign grant    = ws_q &&
                    (({1'b0, main_new} + {1'b0, shadow_q}) < (CNT_W+1)'(TOTAL_LIMIT));

  // Drain decision
  assign drained_n  = {1'b0, drained_q} + 1'b1;
  assign pos_n      = {1'b0, pos_q} + 1'b1;
  assign frame_done = (drained_n >= {1'b0, main_q});
  assign bkt_done   = (pos_n >= {1'b0, cnt_rd_q});

  // Count memory ports
  assign cnt_raddr = draining_q ? bkt_q[BW-1:0] : ins_bkt_q;
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = clr_q;
    cnt_wdata = '0;
    if (cmd_i.clr_step) begin
      cnt_we = 1'b1;
    end else if (cmd_i.ins_commit && room) begin
      cnt_we    = 1'b1;
      cnt_waddr = ins_bkt_q;
      cnt_wdata = cnt_rd_q + 1'b1;
    end else if (cmd_i.drain_commit && (frame_done || bkt_done)) begin
      cnt_we    = 1'b1;
      cnt_waddr = bkt_q[BW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  // Entry memory: bucket times depth plus position
  assign e_bkt    = draining_q ? bkt_q[BW-1:0] : ins_bkt_q;
  assign e_pos    = draining_q ? pos_q : cnt_rd_q;
  assign ent_addr = EW'(e_bkt) * EW'(BUCKET_DEPTH) + EW'(e_pos);
  assign ent_we   = cmd_i.ins_commit && room;

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_addr] <= idx_q;
    end
    ent_rd_q <= ent_mem[ent_addr];
  end

  // Transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      prio_q <= priority_req_i;
      idx_q  <= entry_index_i;
      ws_q   <= want_shadow_i;
    end
  end

  // Frame counters and drain pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_q     <= '0;
      shadow_q   <= '0;
      drained_q  <= '0;
      bkt_q      <= '0;
      pos_q      <= '0;
      draining_q <= 1'b0;
      clr_q      <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= sts_o.clr_last ? '0 : clr_q + 1'b1;
      end
      if (cmd_i.ins_commit) begin
        main_q   <= main_new;
        shadow_q <= shadow_q + CNT_W'(grant);
      end
      if (cmd_i.empty_end || cmd_i.over_end || cmd_i.drain_lost ||
          (cmd_i.drain_commit && frame_done)) begin
        main_q     <= '0;
        shadow_q   <= '0;
        drained_q  <= '0;
        bkt_q      <= '0;
        pos_q      <= '0;
        draining_q <= 1'b0;
      end else if (cmd_i.drain_start) begin
        draining_q <= 1'b1;
        drained_q  <= '0;
        bkt_q      <= '0;
        pos_q      <= '0;
      end else if (cmd_i.drain_skip) begin
        bkt_q <= bkt_q + 1'b1;
        pos_q <= '0;
      end else if (cmd_i.drain_fix) begin
        if ((pos_q >= POS_W'(BUCKET_DEPTH)) || (pos_q >= cnt_rd_q)) begin
          pos_q <= '0;
        end
      end else if (cmd_i.drain_commit) begin
        drained_q <= drained_n[CNT_W-1:0];
        if (bkt_done) begin
          bkt_q <= bkt_q + 1'b1;
          pos_q <= '0;
        end else begin
          pos_q <= pos_n[POS_W-1:0];
        end
      end
    end
  end

  // Staged result
  always_ff @(posedge clk_i) begin
    if (cmd_i.refuse || cmd_i.empty_end || cmd_i.over_end || cmd_i.drain_lost) begin
      res_status_q <= cmd_i.refuse   ? ST_TABLE_FULL :
                      cmd_i.over_end ? ST_OVERFLOW : ST_EMPTY;
      res_sorted_q <= '0;
      res_slot_q   <= '0;
      res_grant_q  <= 1'b0;
      res_sslot_q  <= '0;
      res_last_q   <= 1'b0;
    end else if (cmd_i.ins_commit) begin
      res_status_q <= room ? ST_INSERTED : ST_BUCKET_FULL;
      res_sorted_q <= '0;
      res_slot_q   <= '0;
      res_grant_q  <= grant;
      res_sslot_q  <= grant ? SLOT_W'(shadow_q) : '0;
      res_last_q   <= 1'b0;
    end else if (cmd_i.drain_commit) begin
      res_status_q <= ST_SORTED;
      res_sorted_q <= ent_rd_q;
      res_slot_q   <= SLOT_W'(shadow_q + drained_q);
      res_grant_q  <= 1'b0;
      res_sslot_q  <= '0;
      res_last_q   <= frame_done;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_move) begin
      out_status_q <= res_status_q;
      out_sorted_q <= res_sorted_q;
      out_slot_q   <= res_slot_q;
      out_grant_q  <= res_grant_q;
      out_sslot_q  <= res_sslot_q;
      out_last_q   <= res_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign sorted_index_o   = out_sorted_q;
  assign hw_slot_o        = out_slot_q;
  assign shadow_granted_o = out_grant_q;
  assign shadow_slot_o    = out_sslot_q;
  assign last_o           = out_last_q;

endmodule

[sv/priority_bucket_sprite_sorter_unit.sv]
// Top level of the priority bucket sprite sorter.
// Instantiates pbss_ctrl and pbss_datapath; depends on pbss_pkg.
//
// Sorts sprite indexes into NUM_BUCKETS priority buckets of up to BUCKET_DEPTH
// entries and drains them in ascending bucket number (priority modulo
// NUM_BUCKETS), one entry per drain transaction. One transaction is in work at
// a time. An insert passes through the bucket-number reciprocal step, the count
// read and the write before it presents its result. A drain walks the bucket
// count memory one bucket at a time through its single read port, skipping
// empty buckets, then reads the entry and presents its result. A refused
// insert, an empty frame or an overflow goes from decode straight to its
// result. A result waiting on a stalled output holds the sorter in its last
// step. After reset, and after an overflow or lost-entry frame end, a
// clearing pass zeroes the bucket counts one bucket at a time while input
// stays stalled.
module priority_bucket_sprite_sorter_unit #(
  parameter int NUM_BUCKETS  = pbss_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = pbss_pkg::BUCKET_DEPTH_DEF,
  parameter int TOTAL_LIMIT  = pbss_pkg::TOTAL_LIMIT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [pbss_pkg::PRIO_W-1:0] priority_req_i,
  input  logic [pbss_pkg::IDX_W-1:0]  entry_index_i,
  input  logic                        want_shadow_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [pbss_pkg::IDX_W-1:0]  sorted_index_o,
  output logic [pbss_pkg::SLOT_W-1:0] hw_slot_o,
  output logic                        shadow_granted_o,
  output logic [pbss_pkg::SLOT_W-1:0] shadow_slot_o,
  output logic                        last_o
);
  import pbss_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pbss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pbss_datapath #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .TOTAL_LIMIT  (TOTAL_LIMIT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .kind_i           (kind_i),
    .priority_req_i   (priority_req_i),
    .entry_index_i    (entry_index_i),
    .want_shadow_i    (want_shadow_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .sorted_index_o   (sorted_index_o),
    .hw_slot_o        (hw_slot_o),
    .shadow_granted_o (shadow_granted_o),
    .shadow_slot_o    (shadow_slot_o),
    .last_o           (last_o)
  );

endmodule

[tb/testbench.sv]
// Self-checking testbench for priority_bucket_sprite_sorter_unit.
// A queue-fed driver, a predictor of the bucket sorter and a monitor that checks results in order.
// Depends on pbss_pkg and the RTL of the sorter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pbss_pkg::*;

  localparam int NB = NUM_BUCKETS_DEF;
  localparam int BD = BUCKET_DEPTH_DEF;
  localparam int TL = TOTAL_LIMIT_DEF;
  localparam int CYCLE_LIMIT = 10000000;

  typedef struct {
    logic             kind;
    logic [PRIO_W-1:0] prio;
    logic [IDX_W-1:0]  idx;
    logic             ws;
    bit               sync;   // hold-off marker, not driven
  } sprite_req_t;

  typedef struct {
    logic [2:0]        status;
    logic [IDX_W-1:0]  sorted;
    logic [SLOT_W-1:0] hw_slot;
    logic              granted;
    logic [SLOT_W-1:0] sslot;
    logic              last;
  } sort_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [PRIO_W-1:0] prio = '0;
  logic [IDX_W-1:0] idx = '0;
  logic ws = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [IDX_W-1:0] sorted_index;
  logic [SLOT_W-1:0] hw_slot, shadow_slot;
  logic shadow_granted, last;

  priority_bucket_sprite_sorter_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .priority_req_i(prio), .entry_index_i(idx), .want_shadow_i(ws),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .sorted_index_o(sorted_index), .hw_slot_o(hw_slot),
    .shadow_granted_o(shadow_granted), .shadow_slot_o(shadow_slot), .last_o(last)
  );

  always #2 clk_i = ~clk_i;

  sprite_req_t pending_q[$];
  sort_res_t   expected_q[$];
  int errors = 0;
  int cycles = 0;

  // Sorter mirror state
  logic [IDX_W-1:0] mir_entries[NB*BD];
  int mir_counts[NB];
  int main_cnt, shadow_cnt, drain_bkt, drain_pos, drained_cnt;
  bit draining;

  task automatic close_frame(input bit clr);
    main_cnt = 0; shadow_cnt = 0; draining = 0;
    drain_bkt = 0; drain_pos = 0; drained_cnt = 0;
    if (clr) foreach (mir_counts[i]) mir_counts[i] = 0;
  endtask

  task automatic sort_predict(input sprite_req_t r, output sort_res_t o);
    int b, c, nb;
    o = '{ST_INSERTED, '0, '0, 1'b0, '0, 1'b0};
    if (r.kind == 1'b0) begin
      if (draining || main_cnt + shadow_cnt >= TL) begin
        o.status = ST_TABLE_FULL;
      end else begin
        b = r.prio % NB;
        c = mir_counts[b];
        if (c < BD) begin
          mir_entries[b*BD + c] = r.idx;
          mir_counts[b] = c + 1;
          main_cnt++;
        end else begin
          o.status = ST_BUCKET_FULL;
        end
        if (r.ws && main_cnt + shadow_cnt < TL) begin
          o.granted = 1'b1;
          o.sslot = shadow_cnt[SLOT_W-1:0];
          shadow_cnt++;
        end
      end
    end else begin
      if (!draining) begin
        if (main_cnt == 0) begin
          close_frame(0);
          o.status = ST_EMPTY;
        end else if (main_cnt + shadow_cnt > int'(SLOT_LIMIT)) begin
          close_frame(1);
          o.status = ST_OVERFLOW;
        end else begin
          draining = 1; drain_bkt = 0; drain_pos = 0; drained_cnt = 0;
        end
      end
      if (draining) begin
        nb = -1;
        for (int i = drain_bkt; i < NB; i++)
          if (nb < 0 && mir_counts[i] != 0) nb = i;
        if (nb < 0) begin
          close_frame(1);
          o.status = ST_EMPTY;
        end else begin
          c = mir_counts[nb];
          if (nb != drain_bkt) drain_pos = 0;
          drain_bkt = nb;
          if (drain_pos >= BD || drain_pos >= c) drain_pos = 0;
          o.sorted = mir_entries[nb*BD + drain_pos];
          o.hw_slot = 7'(shadow_cnt + drained_cnt);
          drained_cnt++;
          drain_pos++;
          o.status = ST_SORTED;
          if (drained_cnt >= main_cnt) begin
            mir_counts[nb] = 0;
            o.last = 1'b1;
            close_frame(0);
          end else if (drain_pos >= c) begin
            mir_counts[nb] = 0;
            drain_bkt = nb + 1;
            drain_pos = 0;
          end
        end
      end
    end
  endtask

  // Driver: bursts with random gaps, honors hold-off markers
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    sort_res_t res;
    sprite_req_t r;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        r = '{kind, prio, idx, ws, 1'b0};
        sort_predict(r, res);
        expected_q.push_back(res);
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && pending_q[0].sync) begin
          in_valid <= 1'b0;
          if (expected_q.size() == 0 && !(in_valid && !in_stall)) void'(pending_q.pop_front());
        end else if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_q.size() > 0) begin
          r = pending_q.pop_front();
          in_valid <= 1'b1;
          kind <= r.kind; prio <= r.prio; idx <= r.idx; ws <= r.ws;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor with its own stall pattern, switching periodically to a randomly chosen mode
  int stall_mode = 0;
  always @(posedge clk_i) begin
    sort_res_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("priority_bucket_sprite_sorter_unit: mismatch");
      $finish;
    end else begin
      if (cycles % 300 == 0) stall_mode = $urandom_range(0, 3);
      if (rst_ni && out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result with no transaction outstanding, status %0d", $time, status);
        end else begin
          e = expected_q.pop_front();
          if (status !== e.status || sorted_index !== e.sorted || hw_slot !== e.hw_slot ||
              shadow_granted !== e.granted || shadow_slot !== e.sslot || last !== e.last) begin
            errors++;
            $display("%0t: expected st=%0d idx=%0d hw=%0d sg=%0d ss=%0d last=%0d", $time,
                     e.status, e.sorted, e.hw_slot, e.granted, e.sslot, e.last);
            $display("%0t:   actual st=%0d idx=%0d hw=%0d sg=%0d ss=%0d last=%0d", $time,
                     status, sorted_index, hw_slot, shadow_granted, shadow_slot, last);
          end
        end
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ((cycles % 8) < 3);
      endcase
    end
  end

  task automatic add_req(input logic k, input int p, input int ix, input logic w);
    sprite_req_t r;
    r = '{k, PRIO_W'(p), IDX_W'(ix), w, 1'b0};
    pending_q.push_back(r);
  endtask

  task automatic add_sync();
    sprite_req_t r;
    r = '{1'b0, '0, '0, 1'b0, 1'b1};
    pending_q.push_back(r);
  endtask

  // One frame: inserts then drains, sometimes an insert slipped in mid-drain
  task automatic add_frame(input int n, input int span, input int shadow_pct,
                           inout int items);
    int nd;
    for (int i = 0; i < n; i++)
      add_req(1'b0, $urandom_range(0, span), $urandom_range(0, 255),
              $urandom_range(0, 99) < shadow_pct);
    nd = n + $urandom_range(0, 2);
    for (int i = 0; i < nd; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        add_req(1'b0, $urandom_range(0, 511), $urandom_range(0, 255), $urandom_range(0, 1));
        items++;
      end
      add_req(1'b1, $urandom_range(0, 511), $urandom_range(0, 255), $urandom_range(0, 1));
    end
    items += n + nd;
  endtask

  initial begin
    int items;
    int n;
    close_frame(1);
    foreach (mir_entries[i]) mir_entries[i] = '0;
    // Directed: empty frame, field extremes, bucket full, insert while draining
    add_req(1'b1, 0, 0, 1'b0);
    add_req(1'b0, 0, 0, 1'b1);
    add_req(1'b0, 511, 255, 1'b0);
    add_req(1'b0, 511, 170, 1'b1);
    add_req(1'b1, 511, 255, 1'b1);
    add_req(1'b0, 3, 85, 1'b0);
    add_req(1'b1, 0, 0, 1'b0);
    add_req(1'b1, 0, 0, 1'b0);
    add_req(1'b1, 0, 0, 1'b0);
    for (int i = 0; i < 16; i++) add_req(1'b0, 7, i, 1'b0);
    add_sync();
    for (int i = 0; i < 15; i++) add_req(1'b1, 0, 0, 1'b0);
    items = 40;
    // Random frames: mostly small, some crowded buckets, some over the table limit
    while (items < 1600) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(100, 140);
        1: n = $urandom_range(15, 40);
        default: n = $urandom_range(0, 25);
      endcase
      if ($urandom_range(0, 3) == 0) add_frame(n, $urandom_range(0, 3), 50, items);
      else add_frame(n, 511, $urandom_range(0, 100), items);
      if ($urandom_range(0, 7) == 0) add_sync();
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !in_valid && expected_q.size() == 0);
    repeat (1200) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("priority_bucket_sprite_sorter_unit: match");
    end else begin
      $display("priority_bucket_sprite_sorter_unit: mismatch");
    end
    $finish;
  end
endmodule
